[hw/rtl/chbd_pkg.sv]
`default_nettype none

package chbd_pkg;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam logic [31:0] BODY_LEN_MAX   = 32'hFFFF_FFFF;
   localparam logic [31:0] MAX_BODY_RESET = 32'd4194304;

   // APB: one 32-bit register per word, byte addressed
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_MAX_BODY = '0;

   // Classified input byte, as queued between the front and back parts
   typedef struct packed {
      logic [7:0] byte_val;
      logic       restart;
      logic       hex_ok;
      logic [3:0] hex_val;
      logic       is_cr;
      logic       is_lf;
   } chbd_item_type;

endpackage

`default_nettype wire

[hw/rtl/chbd_req_if.sv]
`default_nettype none

interface chbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       restart;

   modport source (output valid, output body_byte, output restart, input ready);
   modport sink (input valid, input body_byte, input restart, output ready);
endinterface

`default_nettype wire

[hw/rtl/chbd_rsp_if.sv]
`default_nettype none

interface chbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic        body_done;
   logic        format_error;
   logic [31:0] body_length;

   modport source (
      output valid, output payload_byte, output payload_valid, output body_done,
      output format_error, output body_length, input ready
   );
   modport sink (
      input valid, input payload_byte, input payload_valid, input body_done,
      input format_error, input body_length, output ready
   );
endinterface

`default_nettype wire

[hw/rtl/http_chunked_body_deframer.sv]
// Chunked transfer-coding body deframer.
// req_bus carries one raw body byte per transfer plus a restart bit that
// starts a new body with that byte. rsp_bus returns exactly one result per
// input byte: the byte itself when it is chunk payload, body_done once the
// final zero-size chunk and its CR LF are in, a sticky format_error, and the
// saturating sum of completed chunk sizes.
// Throughput is one byte per cycle while rsp_bus takes results. A byte
// accepted on req_bus is classified into a two-entry queue, taken by the
// parser and held in its result register, which drives rsp_bus directly.
// When rsp_bus stalls the parser holds its result and stops; the queue keeps
// taking bytes until its two entries are full, then req_bus.ready drops.
// Reset empties the queue, clears the parser and sets max_body_bytes to
// 4194304. The APB port holds max_body_bytes at address 0; write it only
// while no byte is in flight.
`default_nettype none

module http_chunked_body_deframer
   import chbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   chbd_req_if.sink              req_bus,
   chbd_rsp_if.source            rsp_bus,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire  [CSR_ADDR_W-1:0] paddr,
   input  wire  [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [31:0]    max_body_ff, max_body_in;
   logic           q_valid;
   logic           q_pop;
   chbd_item_type  q_item;
   logic           reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[CSR_ADDR_W-1:2] == REG_MAX_BODY);
   assign prdata  = reg_sel ? max_body_ff : 32'd0;

   always_comb begin
      max_body_in = max_body_ff;
      if (psel && penable && pwrite && pready && reg_sel) begin
         max_body_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= MAX_BODY_RESET;
      end else begin
         max_body_ff <= max_body_in;
      end
   end

   chbd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   chbd_back #(
      .SIZE_BITS (SIZE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .max_body_bytes (max_body_ff),
      .rsp_bus        (rsp_bus)
   );

endmodule

`default_nettype wire

[hw/rtl/chbd_front.sv]
`default_nettype none

module chbd_front
   import chbd_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   chbd_req_if.sink      req_bus,
   output logic          q_valid,
   output chbd_item_type q_item,
   input  wire           q_pop
);

   localparam logic [1:0] QUEUE_FULL = 2'd2;

   chbd_item_type entry_ff [2];
   chbd_item_type item_in;
   logic [1:0]    count_ff, count_in;
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic          push;

   // {ok, value} for 0-9, A-F, a-f
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   assign req_bus.ready = (count_ff != QUEUE_FULL);
   assign push          = req_bus.valid && req_bus.ready;

   always_comb begin
      item_in.byte_val            = req_bus.body_byte;
      item_in.restart             = req_bus.restart;
      {item_in.hex_ok, item_in.hex_val} = hex_decode(req_bus.body_byte);
      item_in.is_cr               = (req_bus.body_byte == CH_CR);
      item_in.is_lf               = (req_bus.body_byte == CH_LF);
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_item  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[hw/rtl/chbd_back.sv]
`default_nettype none

module chbd_back
   import chbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           q_valid,
   input  chbd_item_type q_item,
   output logic          q_pop,
   input  wire  [31:0]   max_body_bytes,
   chbd_rsp_if.source    rsp_bus
);

   localparam int SUM_W = ((SIZE_BITS > 32) ? SIZE_BITS : 32) + 1;

   typedef enum logic [2:0] {
      PH_SIZE_FIRST,
      PH_SIZE_MORE,
      PH_SIZE_LF,
      PH_DATA,
      PH_DATA_CR,
      PH_DATA_LF
   } phase_type;

   phase_type            phase_ff, phase_in, phase_cur;
   logic [SIZE_BITS-1:0] chunk_len_ff, chunk_len_in, chunk_len_cur;
   logic [SIZE_BITS-1:0] remain_ff, remain_in, remain_cur;
   logic [31:0]          seen_ff, seen_in, seen_cur;
   logic [31:0]          total_ff, total_in, total_cur;
   logic                 done_ff, done_in, done_cur;
   logic                 error_ff, error_in, error_cur;
   logic                 emit;
   logic [SUM_W-1:0]     sum;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_pvalid_ff;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      // restart clears everything before the byte is looked at
      if (q_item.restart) begin
         phase_cur     = PH_SIZE_FIRST;
         chunk_len_cur = '0;
         remain_cur    = '0;
         seen_cur      = '0;
         total_cur     = '0;
         done_cur      = 1'b0;
         error_cur     = 1'b0;
      end else begin
         phase_cur     = phase_ff;
         chunk_len_cur = chunk_len_ff;
         remain_cur    = remain_ff;
         seen_cur      = seen_ff;
         total_cur     = total_ff;
         done_cur      = done_ff;
         error_cur     = error_ff;
      end

      phase_in     = phase_cur;
      chunk_len_in = chunk_len_cur;
      remain_in    = remain_cur;
      seen_in      = seen_cur;
      total_in     = total_cur;
      done_in      = done_cur;
      error_in     = error_cur;
      emit         = 1'b0;
      sum          = SUM_W'(total_cur) + SUM_W'(chunk_len_cur);

      if (!error_cur && !done_cur) begin
         seen_in = (seen_cur == BODY_LEN_MAX) ? seen_cur : seen_cur + 32'd1;
         if (seen_in > max_body_bytes) begin
            error_in = 1'b1;
         end else begin
            case (phase_cur)
               PH_SIZE_FIRST, PH_SIZE_MORE: begin
                  if (q_item.is_cr && phase_cur == PH_SIZE_MORE) begin
                     phase_in = PH_SIZE_LF;
                  end else if (!q_item.hex_ok ||
                               chunk_len_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
                     error_in = 1'b1;
                  end else begin
                     chunk_len_in = {chunk_len_cur[SIZE_BITS-5:0], q_item.hex_val};
                     phase_in     = PH_SIZE_MORE;
                  end
               end
               PH_SIZE_LF: begin
                  if (!q_item.is_lf) begin
                     error_in = 1'b1;
                  end else begin
                     remain_in = chunk_len_cur;
                     phase_in  = (chunk_len_cur == '0) ? PH_DATA_CR : PH_DATA;
                  end
               end
               PH_DATA: begin
                  emit      = 1'b1;
                  remain_in = remain_cur - SIZE_BITS'(1);
                  if (remain_cur == SIZE_BITS'(1)) begin
                     phase_in = PH_DATA_CR;
                  end
               end
               PH_DATA_CR: begin
                  if (!q_item.is_cr) begin
                     error_in = 1'b1;
                  end else begin
                     phase_in = PH_DATA_LF;
                  end
               end
               PH_DATA_LF: begin
                  if (!q_item.is_lf) begin
                     error_in = 1'b1;
                  end else if (chunk_len_cur == '0) begin
                     done_in = 1'b1;
                  end else begin
                     total_in     = (sum[SUM_W-1:32] != '0) ? BODY_LEN_MAX : sum[31:0];
                     chunk_len_in = '0;
                     remain_in    = '0;
                     phase_in     = PH_SIZE_FIRST;
                  end
               end
               default: begin
                  error_in = 1'b1;
               end
            endcase
         end
      end

      rsp_valid_in = q_pop ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);
      rsp_byte_in  = emit ? q_item.byte_val : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE_FIRST;
         chunk_len_ff  <= '0;
         remain_ff     <= '0;
         seen_ff       <= '0;
         total_ff      <= '0;
         done_ff       <= 1'b0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_byte_ff   <= '0;
         rsp_pvalid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff      <= phase_in;
            chunk_len_ff  <= chunk_len_in;
            remain_ff     <= remain_in;
            seen_ff       <= seen_in;
            total_ff      <= total_in;
            done_ff       <= done_in;
            error_ff      <= error_in;
            rsp_byte_ff   <= rsp_byte_in;
            rsp_pvalid_ff <= emit;
         end
      end
   end

   // flags and length are read straight from state, which only moves on a pop
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.payload_byte  = rsp_byte_ff;
   assign rsp_bus.payload_valid = rsp_pvalid_ff;
   assign rsp_bus.body_done     = done_ff;
   assign rsp_bus.format_error  = error_ff;
   assign rsp_bus.body_length   = total_ff;

endmodule

`default_nettype wire

[bench/chbd_deframe_checker.sv]
`timescale 1ns / 100ps

module chbd_deframe_checker
   import chbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  wire                  clock,
   input  wire                  reset,
   chbd_req_if                  req_mon,
   chbd_rsp_if                  rsp_mon,
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire [CSR_ADDR_W-1:0] paddr,
   input  wire [31:0]           pwdata,
   input  wire [31:0]           prdata,
   input  wire                  pready,
   output int                   fail_count,
   output int                   pending
);

   localparam logic [CSR_ADDR_W-1:0] MAX_BODY_ADDR = {REG_MAX_BODY, 2'b00};

   typedef enum logic [2:0] {
      SZ_FIRST,
      SZ_MORE,
      SZ_LF,
      PAYLOAD,
      PAY_CR,
      PAY_LF
   } deframe_phase_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        body_done;
      logic        format_error;
      logic [31:0] body_length;
   } deframe_result_type;

   deframe_phase_type      ph;
   logic [SIZE_BITS-1:0]   chunk_len;
   logic [SIZE_BITS-1:0]   chunk_seen;
   logic [31:0]            in_count;
   logic [31:0]            body_total;
   logic [31:0]            body_limit;
   logic                   done_q;
   logic                   err_q;
   deframe_result_type     result_q[$];

   task automatic clear_body();
      ph         = SZ_FIRST;
      chunk_len  = '0;
      chunk_seen = '0;
      in_count   = '0;
      body_total = '0;
      done_q     = 1'b0;
      err_q      = 1'b0;
   endtask

   // Advance the deframer state by one body byte and work out its result.
   task automatic deframe_byte(input logic [7:0] c, input logic restart_bit,
                               output deframe_result_type r);
      logic       emit;
      logic       hex_ok;
      logic [3:0] nib;
      logic [64:0] sum;
      emit = 1'b0;
      if (restart_bit)
         clear_body();
      if (!err_q && !done_q) begin
         if (in_count != BODY_LEN_MAX)
            in_count = in_count + 32'd1;
         if (in_count > body_limit) begin
            err_q = 1'b1;
         end else begin
            hex_ok = 1'b1;
            nib    = '0;
            if (c >= "0" && c <= "9")
               nib = 4'(c - "0");
            else if (c >= "A" && c <= "F")
               nib = 4'(c - "A" + 8'd10);
            else if (c >= "a" && c <= "f")
               nib = 4'(c - "a" + 8'd10);
            else
               hex_ok = 1'b0;
            case (ph)
               SZ_FIRST, SZ_MORE: begin
                  if (c == CH_CR && ph == SZ_MORE)
                     ph = SZ_LF;
                  else if (!hex_ok || chunk_len[SIZE_BITS-1 -: 4] != '0)
                     err_q = 1'b1;
                  else begin
                     chunk_len = {chunk_len[SIZE_BITS-5:0], nib};
                     ph = SZ_MORE;
                  end
               end
               SZ_LF: begin
                  if (c != CH_LF)
                     err_q = 1'b1;
                  else begin
                     chunk_seen = '0;
                     ph = (chunk_len == '0) ? PAY_CR : PAYLOAD;
                  end
               end
               PAYLOAD: begin
                  emit = 1'b1;
                  chunk_seen = chunk_seen + SIZE_BITS'(1);
                  if (chunk_seen >= chunk_len)
                     ph = PAY_CR;
               end
               PAY_CR: begin
                  if (c != CH_CR)
                     err_q = 1'b1;
                  else
                     ph = PAY_LF;
               end
               PAY_LF: begin
                  if (c != CH_LF)
                     err_q = 1'b1;
                  else if (chunk_len == '0)
                     done_q = 1'b1;
                  else begin
                     sum = 65'(body_total) + 65'(chunk_len);
                     body_total = (sum > 65'(BODY_LEN_MAX)) ? BODY_LEN_MAX : sum[31:0];
                     chunk_len  = '0;
                     chunk_seen = '0;
                     ph = SZ_FIRST;
                  end
               end
               default: err_q = 1'b1;
            endcase
         end
         if (err_q)
            emit = 1'b0;
      end
      r.payload_byte  = emit ? c : 8'h00;
      r.payload_valid = emit;
      r.body_done     = done_q;
      r.format_error  = err_q;
      r.body_length   = body_total;
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      deframe_result_type want;
      deframe_result_type fresh;
      if (reset) begin
         body_limit = MAX_BODY_RESET;
         clear_body();
         result_q.delete();
      end else begin
         if (psel && penable && pready && paddr == MAX_BODY_ADDR) begin
            if (pwrite)
               body_limit = pwdata;
            else
               check_field("prdata", body_limit, prdata);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (result_q.size() == 0) begin
               $error("result transfer with no byte outstanding");
               fail_count++;
            end else begin
               want = result_q.pop_front();
               check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_mon.payload_byte));
               check_field("payload_valid", 32'(want.payload_valid),
                           32'(rsp_mon.payload_valid));
               check_field("body_done", 32'(want.body_done), 32'(rsp_mon.body_done));
               check_field("format_error", 32'(want.format_error),
                           32'(rsp_mon.format_error));
               check_field("body_length", want.body_length, rsp_mon.body_length);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            deframe_byte(req_mon.body_byte, req_mon.restart, fresh);
            result_q.push_back(fresh);
         end
      end
      pending = result_q.size();
   end

endmodule

[bench/tb_http_chunked_body_deframer.sv]
`timescale 1ns / 100ps

module tb_http_chunked_body_deframer;
   import chbd_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending;

   logic                  steady;
   logic                  restart_next;
   logic                  body_live;
   int                    noise_pct;
   int                    bytes_sent;
   int                    live_bytes;
   int                    bodies_sent;
   logic [31:0]           limit_plan[6];

   chbd_req_if req_if();
   chbd_rsp_if rsp_if();

   http_chunked_body_deframer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   chbd_deframe_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 37);
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < 37) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.body_byte <= b;
      req_if.restart   <= restart_next;
      restart_next = 1'b0;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      bytes_sent++;
      if (body_live)
         live_bytes++;
   endtask

   // framing bytes get corrupted now and then on noisy bodies
   task automatic send_framed(input logic [7:0] b);
      if ($urandom_range(99) < noise_pct)
         send_byte(8'($urandom));
      else
         send_byte(b);
   endtask

   task automatic send_size_line(input logic [39:0] size, input int pad);
      int         n;
      logic [3:0] nib;
      logic [7:0] c;
      n = 1;
      for (int i = 1; i < 10; i++)
         if (size[4*i +: 4] != 4'h0)
            n = i + 1;
      repeat (pad) send_framed("0");
      for (int i = n - 1; i >= 0; i--) begin
         nib = size[4*i +: 4];
         if (nib < 4'd10)
            c = "0" + 8'(nib);
         else
            c = ($urandom_range(1) ? "A" : "a") + 8'(nib) - 8'd10;
         send_framed(c);
      end
      send_framed(CH_CR);
      send_framed(CH_LF);
   endtask

   task automatic send_chunk(input int size);
      send_size_line(40'(size), ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
      repeat (size) send_byte(8'($urandom));
      send_framed(CH_CR);
      send_framed(CH_LF);
   endtask

   task automatic random_body();
      int kind;
      kind = $urandom_range(99);
      noise_pct = ($urandom_range(99) < 15) ? 4 : 0;
      restart_next = (kind >= 5);
      body_live = restart_next;
      bodies_sent++;
      if (kind < 75) begin
         repeat ($urandom_range(3))
            send_chunk(($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1));
         if ($urandom_range(9) != 0)
            send_chunk(0);
      end else if (kind < 85) begin
         // huge size that is never completed; most bodies start with a restart
         send_size_line(40'($urandom_range(32'hFFFF_FFFF, 32'h0001_0000)), 0);
         repeat ($urandom_range(6)) send_byte(8'($urandom));
      end else if (kind < 92) begin
         // nine digits: the size no longer fits
         send_size_line({4'h0, 4'($urandom_range(15, 1)), 32'($urandom)}, 0);
      end else begin
         repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
      end
   endtask

   // Drain everything in flight, then write max_body_bytes and read it back.
   task automatic program_limit(input logic [31:0] value);
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_MAX_BODY, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_if.valid     = 1'b0;
      req_if.body_byte = '0;
      req_if.restart   = 1'b0;
      rsp_if.ready     = 1'b0;
      steady           = 1'b0;
      restart_next     = 1'b0;
      body_live        = 1'b1;
      noise_pct        = 0;
      bytes_sent       = 0;
      live_bytes       = 0;
      bodies_sent      = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // two payload bytes at the byte extremes, then the terminating zero chunk
      restart_next = 1'b1;
      send_byte("2");
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte("0");
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte("7");          // after done: ignored
      // empty size line, then a byte that the error swallows
      restart_next = 1'b1;
      send_byte(CH_CR);
      send_byte(CH_LF);
      // nine digits overflow the size
      restart_next = 1'b1;
      send_byte("f");
      repeat (4) send_byte("F");
      repeat (4) send_byte("f");
      // body limit trips on the fourth byte
      program_limit(32'd3);
      restart_next = 1'b1;
      send_byte("1");
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte("Z");

      limit_plan = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'($urandom_range(60, 8)),
                     32'($urandom_range(600, 100)), MAX_BODY_RESET};
      foreach (limit_plan[i]) begin
         program_limit(limit_plan[i]);
         steady = (i == 5);
         live_bytes = 0;
         while (live_bytes < 210)
            random_body();
      end

      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      $display("Sent %0d body bytes in %0d bodies across %0d body limit settings,",
               bytes_sent, bodies_sent, $size(limit_plan) + 1);
      $display("including framing errors, size overflow, limit trips and restarts.");
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[http_chunked_body_deframer.f]
hw/rtl/chbd_pkg.sv
hw/rtl/chbd_req_if.sv
hw/rtl/chbd_rsp_if.sv
hw/rtl/chbd_front.sv
hw/rtl/chbd_back.sv
hw/rtl/http_chunked_body_deframer.sv
bench/chbd_deframe_checker.sv
bench/tb_http_chunked_body_deframer.sv
